FILE: rtl/core/qfba_pkg.sv
package qfba_pkg;

  localparam int HANDLE_W    = 8;
  localparam int SIZE_W      = 16;
  localparam int CLASS_W     = 2;
  localparam int STATUS_W    = 2;
  localparam int FRESH_W     = 9;
  localparam int POOL_DEPTH  = 256;
  localparam int LIMIT_COUNT = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - HANDLE_W - CLASS_W;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NULL_FREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SMALL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MEDIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LARGE  = 2'd2;

  localparam logic [SIZE_W-1:0] RST_LIMIT_SMALL  = 16'd50;
  localparam logic [SIZE_W-1:0] RST_LIMIT_MEDIUM = 16'd100;
  localparam logic [SIZE_W-1:0] RST_LIMIT_LARGE  = 16'd200;

  typedef struct packed {
    logic start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_read;
  } dp_stat_t;

endpackage

FILE: rtl/core/qfba_ram.sv
module qfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/qfba_ctrl.sv
module qfba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  qfba_pkg::dp_stat_t  stat,
  output qfba_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign cmd.start  = in_tvalid && in_tready;
  assign cmd.finish = (state_r == S_READ) && out_free;
  assign load = (cmd.start && !stat.needs_read) || cmd.finish;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start && stat.needs_read) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // hold until the output register can take the result
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/qfba_dp.sv
module qfba_dp #(
  parameter int CLASS_COUNT = 3,
  parameter int POOL_BLOCKS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [qfba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qfba_pkg::SIZE_W-1:0]        cfg_wdata,
  input  logic                               command,
  input  logic [qfba_pkg::SIZE_W-1:0]        request_size,
  input  logic [qfba_pkg::HANDLE_W-1:0]      block_handle,
  input  qfba_pkg::ctrl_cmd_t                cmd,
  output qfba_pkg::dp_stat_t                 stat,
  output logic [qfba_pkg::HANDLE_W-1:0]      granted_handle,
  output logic [qfba_pkg::CLASS_W-1:0]       size_class,
  output logic [qfba_pkg::STATUS_W-1:0]      status
);

  localparam int FreshLimit = (POOL_BLOCKS < qfba_pkg::POOL_DEPTH) ?
                              POOL_BLOCKS : qfba_pkg::POOL_DEPTH;

  logic [qfba_pkg::SIZE_W-1:0]   limit_r [qfba_pkg::LIMIT_COUNT];
  logic [qfba_pkg::HANDLE_W-1:0] heads_r [CLASS_COUNT];
  logic [qfba_pkg::FRESH_W-1:0]  fresh_r;

  logic                          op_r;
  logic [qfba_pkg::HANDLE_W-1:0] handle_r;
  logic [qfba_pkg::CLASS_W-1:0]  cls_r;

  logic [qfba_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [qfba_pkg::CLASS_W-1:0]  out_class_r, out_class_nxt;
  logic [qfba_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                          fit;
  logic [qfba_pkg::CLASS_W-1:0]  fit_cls;
  logic [qfba_pkg::HANDLE_W-1:0] fit_head;
  logic                          exhausted;
  logic                          take_fresh;

  logic [qfba_pkg::CLASS_W-1:0]  free_cls;
  logic [qfba_pkg::HANDLE_W-1:0] free_head;

  logic                          nl_we, nl_re;
  logic [qfba_pkg::HANDLE_W-1:0] nl_rdata;
  logic                          bc_we, bc_re;
  logic [qfba_pkg::CLASS_W-1:0]  bc_rdata;

  // first class in index order whose limit covers the size
  always_comb begin
    fit     = 1'b0;
    fit_cls = '0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (request_size <= limit_r[c]) begin
        fit     = 1'b1;
        fit_cls = qfba_pkg::CLASS_W'(c);
      end
    end
  end

  always_comb begin
    fit_head = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (fit_cls == qfba_pkg::CLASS_W'(c)) begin
        fit_head = heads_r[c];
      end
    end
  end

  // a recorded class beyond the configured count falls back to class zero
  assign free_cls = (bc_rdata >= qfba_pkg::CLASS_W'(CLASS_COUNT)) ? '0 : bc_rdata;

  always_comb begin
    free_head = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (free_cls == qfba_pkg::CLASS_W'(c)) begin
        free_head = heads_r[c];
      end
    end
  end

  assign exhausted = fresh_r >= qfba_pkg::FRESH_W'(FreshLimit);

  always_comb begin
    if (command == qfba_pkg::CMD_ALLOC) begin
      stat.needs_read = fit && (fit_head != '0);
    end else begin
      stat.needs_read = block_handle != '0;
    end
  end

  assign take_fresh = cmd.start && (command == qfba_pkg::CMD_ALLOC) && fit &&
                      (fit_head == '0) && !exhausted;

  assign nl_re = cmd.start && (command == qfba_pkg::CMD_ALLOC) && stat.needs_read;
  assign nl_we = cmd.finish && (op_r == qfba_pkg::CMD_FREE);
  assign bc_re = cmd.start && (command == qfba_pkg::CMD_FREE) && stat.needs_read;
  assign bc_we = take_fresh;

  qfba_ram #(
    .WIDTH (qfba_pkg::HANDLE_W),
    .DEPTH (qfba_pkg::POOL_DEPTH)
  ) u_next_links (
    .clk   (clk),
    .we    (nl_we),
    .waddr (handle_r),
    .wdata (free_head),
    .re    (nl_re),
    .raddr (fit_head),
    .rdata (nl_rdata)
  );

  qfba_ram #(
    .WIDTH (qfba_pkg::CLASS_W),
    .DEPTH (qfba_pkg::POOL_DEPTH)
  ) u_block_classes (
    .clk   (clk),
    .we    (bc_we),
    .waddr (fresh_r[qfba_pkg::HANDLE_W-1:0]),
    .wdata (fit_cls),
    .re    (bc_re),
    .raddr (block_handle),
    .rdata (bc_rdata)
  );

  always_comb begin
    out_handle_nxt = out_handle_r;
    out_class_nxt  = out_class_r;
    out_status_nxt = out_status_r;
    if (cmd.finish) begin
      if (op_r == qfba_pkg::CMD_ALLOC) begin
        out_handle_nxt = handle_r;
        out_class_nxt  = cls_r;
      end else begin
        out_handle_nxt = '0;
        out_class_nxt  = free_cls;
      end
      out_status_nxt = qfba_pkg::ST_OK;
    end else if (cmd.start && !stat.needs_read) begin
      out_handle_nxt = '0;
      out_class_nxt  = '0;
      if (command == qfba_pkg::CMD_FREE) begin
        out_status_nxt = qfba_pkg::ST_NULL_FREE;
      end else if (!fit) begin
        out_status_nxt = qfba_pkg::ST_TOO_LARGE;
      end else if (exhausted) begin
        out_class_nxt  = fit_cls;
        out_status_nxt = qfba_pkg::ST_EXHAUSTED;
      end else begin
        out_handle_nxt = fresh_r[qfba_pkg::HANDLE_W-1:0];
        out_class_nxt  = fit_cls;
        out_status_nxt = qfba_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_handle_r <= out_handle_nxt;
    out_class_r  <= out_class_nxt;
    out_status_r <= out_status_nxt;
    if (cmd.start) begin
      op_r     <= command;
      cls_r    <= fit_cls;
      handle_r <= (command == qfba_pkg::CMD_ALLOC) ? fit_head : block_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[0] <= qfba_pkg::RST_LIMIT_SMALL;
      limit_r[1] <= qfba_pkg::RST_LIMIT_MEDIUM;
      limit_r[2] <= qfba_pkg::RST_LIMIT_LARGE;
    end else if (cfg_we) begin
      case (cfg_index)
        qfba_pkg::CFG_LIMIT_SMALL:  limit_r[0] <= cfg_wdata;
        qfba_pkg::CFG_LIMIT_MEDIUM: limit_r[1] <= cfg_wdata;
        qfba_pkg::CFG_LIMIT_LARGE:  limit_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= qfba_pkg::FRESH_W'(1);
    end else if (take_fresh) begin
      fresh_r <= fresh_r + qfba_pkg::FRESH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        heads_r[c] <= '0;
      end
    end else if (cmd.finish) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        // pop advances the head to its link, push makes the freed handle the head
        if (op_r == qfba_pkg::CMD_ALLOC && cls_r == qfba_pkg::CLASS_W'(c)) begin
          heads_r[c] <= nl_rdata;
        end else if (op_r == qfba_pkg::CMD_FREE && free_cls == qfba_pkg::CLASS_W'(c)) begin
          heads_r[c] <= handle_r;
        end
      end
    end
  end

  assign granted_handle = out_handle_r;
  assign size_class     = out_class_r;
  assign status         = out_status_r;

endmodule

FILE: rtl/core/quick_fit_block_allocator_top.sv
// Quick-fit block allocator. Each request on in_ allocates a block for a size
// (in_tuser low) or frees a block by its handle (in_tuser high); one result per
// request leaves on out_. Allocation picks the first size class whose limit
// covers the size, pops that class's free list, and otherwise hands out the
// next fresh handle from the pool. A request that needs no table lookup (fresh
// allocate, size too large, pool exhausted, null free) is served from the idle
// state; one that pops a list or frees a block goes through the read state for
// the registered read of the link or class RAM. A new request is taken while the
// previous result still sits in the output register, as long as that register
// is drained by then. Both RAMs need no clearing after reset; the block takes
// requests right out of reset. Limits may be rewritten only while idle.
module quick_fit_block_allocator_top #(
  parameter int CLASS_COUNT = 3,
  parameter int POOL_BLOCKS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [qfba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qfba_pkg::SIZE_W-1:0]        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // request_size [15:0], block_handle [23:16]
  input  logic [qfba_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // granted_handle [7:0], size_class [9:8], zero fill above
  output logic [qfba_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [qfba_pkg::STATUS_W-1:0]      out_tuser
);

  qfba_pkg::ctrl_cmd_t           cmd;
  qfba_pkg::dp_stat_t            stat;
  logic [qfba_pkg::HANDLE_W-1:0] granted_handle;
  logic [qfba_pkg::CLASS_W-1:0]  size_class;

  qfba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  qfba_dp #(
    .CLASS_COUNT (CLASS_COUNT),
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .command        (in_tuser),
    .request_size   (in_tdata[qfba_pkg::SIZE_W-1:0]),
    .block_handle   (in_tdata[qfba_pkg::SIZE_W +: qfba_pkg::HANDLE_W]),
    .cmd            (cmd),
    .stat           (stat),
    .granted_handle (granted_handle),
    .size_class     (size_class),
    .status         (out_tuser)
  );

  assign out_tdata = {{qfba_pkg::OUT_PAD_W{1'b0}}, size_class, granted_handle};

endmodule

FILE: rtl/core/qfba_chk.sv
module qfba_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [qfba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [qfba_pkg::STATUS_W-1:0]    out_tuser
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before it was taken");

  a_too_large_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == qfba_pkg::ST_TOO_LARGE |-> out_tdata == '0)
    else $error("oversize request carries a handle or class");

  a_null_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == qfba_pkg::ST_NULL_FREE |-> out_tdata == '0)
    else $error("null free carries a handle or class");

  a_exhausted_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == qfba_pkg::ST_EXHAUSTED |->
      out_tdata[qfba_pkg::HANDLE_W-1:0] == '0)
    else $error("exhausted pool still grants a handle");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[qfba_pkg::HANDLE_W +: qfba_pkg::CLASS_W] != 2'd3)
    else $error("size class out of range");

endmodule

bind quick_fit_block_allocator_top qfba_chk u_qfba_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/qfba_grant_checker.sv
`timescale 1ns / 1ps

module qfba_grant_checker
  import qfba_pkg::*;
#(
  parameter int CLASS_COUNT = 3,
  parameter int POOL_BLOCKS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // request_size [15:0], block_handle [23:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // granted_handle [7:0], size_class [9:8], zero fill above
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  input  logic [STATUS_W-1:0]    out_tuser,
  output int                     outstanding,
  output int                     mismatches
);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [CLASS_W-1:0]  size_class;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic [SIZE_W-1:0]   limit_of [LIMIT_COUNT];
  logic [HANDLE_W-1:0] head_of  [LIMIT_COUNT];
  logic [HANDLE_W-1:0] link_of  [POOL_DEPTH];
  logic [CLASS_W-1:0]  class_of [POOL_DEPTH];
  logic [FRESH_W-1:0]  fresh_next;
  reply_t              owed_replies [$];
  int                  errs = 0;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic reply_t serve_request(input logic cmd, input logic [SIZE_W-1:0] size,
                                           input logic [HANDLE_W-1:0] handle);
    reply_t              r;
    int                  pick;
    logic [HANDLE_W-1:0] top_free;
    logic [CLASS_W-1:0]  rc;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      pick = -1;
      // first class in index order wins, even with limits out of order
      for (int c = 0; c < CLASS_COUNT && c < LIMIT_COUNT; c++) begin
        if (pick < 0 && size <= limit_of[c]) pick = c;
      end
      if (pick < 0) begin
        r.status = ST_TOO_LARGE;
      end else begin
        r.size_class = pick[CLASS_W-1:0];
        top_free = head_of[pick];
        if (top_free != '0) begin
          head_of[pick] = link_of[top_free];
          r.handle      = top_free;
          r.status      = ST_OK;
        end else if (fresh_next >= POOL_BLOCKS || fresh_next > 255) begin
          r.status = ST_EXHAUSTED;
        end else begin
          r.handle = fresh_next[HANDLE_W-1:0];
          class_of[fresh_next[HANDLE_W-1:0]] = pick[CLASS_W-1:0];
          fresh_next = fresh_next + FRESH_W'(1);
          r.status   = ST_OK;
        end
      end
    end else if (handle == '0) begin
      r.status = ST_NULL_FREE;
    end else begin
      rc = class_of[handle];
      if (rc >= CLASS_COUNT) rc = '0;
      link_of[handle] = head_of[rc];
      head_of[rc]     = handle;
      r.size_class    = rc;
      r.status        = ST_OK;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : track
    reply_t want;
    if (!rst_n) begin
      limit_of[0] = RST_LIMIT_SMALL;
      limit_of[1] = RST_LIMIT_MEDIUM;
      limit_of[2] = RST_LIMIT_LARGE;
      for (int i = 0; i < LIMIT_COUNT; i++) head_of[i] = '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        link_of[i]  = '0;
        class_of[i] = '0;
      end
      fresh_next = FRESH_W'(1);
      owed_replies.delete();
    end else begin
      // compare before queuing: a request accepted now cannot be answered now
      if (out_tvalid && out_tready) begin
        if (owed_replies.size() == 0) begin
          $error("reply with no request outstanding: tdata %h, tuser %h", out_tdata, out_tuser);
          errs++;
        end else begin
          want = owed_replies.pop_front();
          check_field("granted_handle", int'(want.handle), int'(out_tdata[HANDLE_W-1:0]));
          check_field("size_class", int'(want.size_class),
                      int'(out_tdata[HANDLE_W +: CLASS_W]));
          check_field("status", int'(want.status), int'(out_tuser));
          check_field("zero fill", 0, int'(out_tdata[OUT_TDATA_W-1:HANDLE_W+CLASS_W]));
        end
      end
      // drop writes past the last limit register
      if (cfg_we && cfg_index <= CFG_LIMIT_LARGE) limit_of[cfg_index] = cfg_wdata;
      if (in_tvalid && in_tready) begin
        owed_replies.push_back(serve_request(in_tuser, in_tdata[SIZE_W-1:0],
                                             in_tdata[SIZE_W +: HANDLE_W]));
      end
    end
    outstanding <= owed_replies.size();
    mismatches  <= errs;
  end

endmodule

FILE: tb/tb_quick_fit_block_allocator_top.sv
`timescale 1ns / 1ps

module tb_quick_fit_block_allocator_top;
  import qfba_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int QUIET_LIMIT = 2000;

  typedef enum int {DRAIN_ALL, DRAIN_COIN, DRAIN_MOST, DRAIN_HOLD} drain_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SIZE_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  int                     outstanding;
  int                     mismatches;

  logic [SIZE_W-1:0]   cur_limit [LIMIT_COUNT];
  logic [HANDLE_W-1:0] live_handles [$];
  logic [HANDLE_W-1:0] issued_list [$];
  bit                  issued [POOL_DEPTH];
  int                  burst_left = 1;
  int                  quiet_cycles = 0;
  int                  ready_left = 0;
  drain_mode_t         ready_mode = DRAIN_ALL;

  quick_fit_block_allocator_top #(
    .CLASS_COUNT(3),
    .POOL_BLOCKS(256)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  qfba_grant_checker #(
    .CLASS_COUNT(3),
    .POOL_BLOCKS(256)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #2 clk = ~clk;

  // receiver: windows of full flow, coin-flip, mostly ready, or a solid stall
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = drain_mode_t'($urandom_range(3));
      ready_left = (ready_mode == DRAIN_HOLD) ? $urandom_range(1, 30) : $urandom_range(8, 60);
    end
    ready_left--;
    case (ready_mode)
      DRAIN_ALL:  out_tready <= 1'b1;
      DRAIN_COIN: out_tready <= 1'($urandom_range(1));
      DRAIN_MOST: out_tready <= ($urandom_range(3) != 0);
      default:    out_tready <= 1'b0;
    endcase
  end

  // remember every handle the block has granted, for later frees
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tuser == ST_OK
        && out_tdata[HANDLE_W-1:0] != '0) begin
      live_handles.push_back(out_tdata[HANDLE_W-1:0]);
      if (!issued[out_tdata[HANDLE_W-1:0]]) begin
        issued[out_tdata[HANDLE_W-1:0]] = 1'b1;
        issued_list.push_back(out_tdata[HANDLE_W-1:0]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(input logic cmd, input logic [SIZE_W-1:0] size,
                              input logic [HANDLE_W-1:0] handle);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {handle, size};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic free_block(input logic [HANDLE_W-1:0] handle);
    for (int i = 0; i < live_handles.size(); i++) begin
      if (live_handles[i] == handle) begin
        live_handles.delete(i);
        break;
      end
    end
    push_request(CMD_FREE, SIZE_W'($urandom), handle);
  endtask

  // hold off until every reply is back and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [SIZE_W-1:0] lim_s, input logic [SIZE_W-1:0] lim_m,
                            input logic [SIZE_W-1:0] lim_l);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIMIT_SMALL;
    cfg_wdata <= lim_s;
    @(posedge clk);
    cfg_index <= CFG_LIMIT_MEDIUM;
    cfg_wdata <= lim_m;
    @(posedge clk);
    cfg_index <= CFG_LIMIT_LARGE;
    cfg_wdata <= lim_l;
    @(posedge clk);
    // the spare index must be ignored
    cfg_index <= CFG_UNUSED_IDX;
    cfg_wdata <= SIZE_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_limit[0] = lim_s;
    cur_limit[1] = lim_m;
    cur_limit[2] = lim_l;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int k;
    int sz;
    k = $urandom_range(9);
    if (k < 5) begin
      sz = int'(cur_limit[$urandom_range(2)]) + $urandom_range(2) - 1;
      if (sz < 0) sz = 0;
      if (sz > 65535) sz = 65535;
    end else if (k < 7) begin
      sz = $urandom_range(300);
    end else if (k < 9) begin
      sz = $urandom_range(65535);
    end else begin
      sz = $urandom_range(1) ? 65535 : 0;
    end
    return sz[SIZE_W-1:0];
  endfunction

  task automatic random_request(input int alloc_pct);
    int r;
    r = $urandom_range(99);
    if (r < alloc_pct || issued_list.size() == 0) begin
      push_request(CMD_ALLOC, pick_size(), HANDLE_W'($urandom));
    end else begin
      r = $urandom_range(99);
      if (r < 4) begin
        free_block('0);
      end else if (r < 10 || live_handles.size() == 0) begin
        // free of any handle granted at some point: live, stale or a double free
        free_block(issued_list[$urandom_range(issued_list.size() - 1)]);
      end else begin
        free_block(live_handles[$urandom_range(live_handles.size() - 1)]);
      end
    end
  endtask

  task automatic run_phase(input int count, input int alloc_pct);
    repeat (count) random_request(alloc_pct);
  endtask

  initial begin
    cur_limit[0] = RST_LIMIT_SMALL;
    cur_limit[1] = RST_LIMIT_MEDIUM;
    cur_limit[2] = RST_LIMIT_LARGE;
    burst_left = $urandom_range(1, 40);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: class edges at reset limits, then LIFO reuse and double free
    push_request(CMD_ALLOC, 16'd0, 8'h00);
    push_request(CMD_ALLOC, 16'd50, 8'hFF);
    push_request(CMD_ALLOC, 16'd51, 8'h00);
    push_request(CMD_ALLOC, 16'd100, 8'hAA);
    push_request(CMD_ALLOC, 16'd101, 8'h55);
    push_request(CMD_ALLOC, 16'd200, 8'h00);
    push_request(CMD_ALLOC, 16'd201, 8'h00);
    push_request(CMD_ALLOC, 16'hFFFF, 8'hFF);
    push_request(CMD_FREE, 16'hFFFF, 8'h00);
    free_block(8'd2);
    free_block(8'd1);
    push_request(CMD_ALLOC, 16'd10, 8'h00);
    push_request(CMD_ALLOC, 16'd20, 8'h00);
    free_block(8'd4);
    free_block(8'd3);
    push_request(CMD_ALLOC, 16'd75, 8'h00);
    free_block(8'd6);
    free_block(8'd6);
    push_request(CMD_ALLOC, 16'd150, 8'h00);
    push_request(CMD_ALLOC, 16'd199, 8'h00);
    free_block(8'd5);
    push_request(CMD_ALLOC, 16'd100, 8'h00);

    run_phase(320, 55);
    set_limits(16'd0, 16'd1000, 16'd65535);
    run_phase(300, 60);
    set_limits(16'd1000, 16'd10, 16'd5000);
    run_phase(300, 85);
    // everything fits class zero: drives the fresh counter to the end of the pool
    set_limits(16'd65535, 16'd65535, 16'd65535);
    run_phase(230, 95);
    set_limits(16'd30, 16'd31, 16'd65535);
    run_phase(260, 50);
    set_limits(16'd65535, 16'd0, 16'd0);
    run_phase(220, 50);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/qfba_pkg.sv
rtl/core/qfba_ram.sv
rtl/core/qfba_ctrl.sv
rtl/core/qfba_dp.sv
rtl/core/quick_fit_block_allocator_top.sv
rtl/core/qfba_chk.sv
tb/qfba_grant_checker.sv
tb/tb_quick_fit_block_allocator_top.sv
